FILE: design/rqdp_pkg.sv
// Package for the ring queue with drop and peek.
// Holds field widths, operation codes, controller state codes and control structs.
// No dependencies.
package rqdp_pkg;

    localparam int DEPTH_DEFAULT       = 16;
    localparam int ENTRY_WIDTH_DEFAULT = 32;

    localparam int OP_W     = 3;
    localparam int ENTRY_W  = 32;
    localparam int OFFSET_W = 4;
    localparam int COUNT_W  = 4;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR     = 3'd0,
        OP_PUSH      = 3'd1,
        OP_PUSH_DROP = 3'd2,
        OP_POP       = 3'd3,
        OP_PEEK      = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    typedef struct packed {
        logic capture;
        logic execute;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
    } ctrl_status_t;

endpackage

FILE: design/rqdp_item_if.sv
// Input channel of the ring queue: valid/ready handshake with one operation item.
// Depends on rqdp_pkg for field widths.
interface rqdp_item_if;
    logic                              valid;
    logic                              ready;
    logic [rqdp_pkg::OP_W-1:0]         op;
    logic                              from_newest;
    logic [rqdp_pkg::ENTRY_W-1:0]      entry_in;
    logic [rqdp_pkg::OFFSET_W-1:0]     offset;

    modport source (output valid, output op, output from_newest, output entry_in,
                    output offset, input ready);
    modport sink   (input valid, input op, input from_newest, input entry_in,
                    input offset, output ready);
endinterface

FILE: design/rqdp_result_if.sv
// Output channel of the ring queue: valid/ready handshake with one result item.
// Depends on rqdp_pkg for field widths.
interface rqdp_result_if;
    logic                              valid;
    logic                              ready;
    logic                              ok;
    logic [rqdp_pkg::ENTRY_W-1:0]      entry_out;
    logic [rqdp_pkg::COUNT_W-1:0]      count;
    logic                              empty_res;
    logic                              full_res;

    modport source (output valid, output ok, output entry_out, output count,
                    output empty_res, output full_res, input ready);
    modport sink   (input valid, input ok, input entry_out, input count,
                    input empty_res, input full_res, output ready);
endinterface

FILE: design/rqdp_ctrl.sv
// Controller of the ring queue: two-state machine that sequences accept and execute.
// Depends on rqdp_pkg for state codes and command/status structs.
module rqdp_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  rqdp_pkg::ctrl_status_t status,
    output rqdp_pkg::ctrl_cmd_t   cmd
);

    rqdp_pkg::state_t state_reg;
    rqdp_pkg::state_t state_next;

    always_comb
    begin
        state_next  = state_reg;
        req_ready   = 1'b0;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        unique case (state_reg)
            rqdp_pkg::ST_IDLE:
            begin
                req_ready   = 1'b1;
                cmd.capture = req_valid;
                if (req_valid)
                begin
                    state_next = rqdp_pkg::ST_EXEC;
                end
            end
            rqdp_pkg::ST_EXEC:
            begin
                cmd.execute = status.out_free;
                if (status.out_free)
                begin
                    state_next = rqdp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rqdp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rqdp_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: design/rqdp_datapath.sv
// Datapath of the ring queue: slot memory, head/tail pointers, item and result registers.
// Depends on rqdp_pkg; driven by commands from rqdp_ctrl.
module rqdp_datapath #(
    parameter int DEPTH       = rqdp_pkg::DEPTH_DEFAULT,
    parameter int ENTRY_WIDTH = rqdp_pkg::ENTRY_WIDTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  rqdp_pkg::ctrl_cmd_t               cmd,
    output rqdp_pkg::ctrl_status_t            status,
    input  logic [rqdp_pkg::OP_W-1:0]         op,
    input  logic                              from_newest,
    input  logic [rqdp_pkg::ENTRY_W-1:0]      entry_in,
    input  logic [rqdp_pkg::OFFSET_W-1:0]     offset,
    input  logic                              rsp_ready,
    output logic                              rsp_valid,
    output logic                              ok,
    output logic [rqdp_pkg::ENTRY_W-1:0]      entry_out,
    output logic [rqdp_pkg::COUNT_W-1:0]      count,
    output logic                              empty_res,
    output logic                              full_res
);

    localparam int IW   = $clog2(DEPTH);
    localparam int AW   = IW + 1;
    localparam int SW   = (ENTRY_WIDTH < rqdp_pkg::ENTRY_W) ? ENTRY_WIDTH : rqdp_pkg::ENTRY_W;
    localparam int CMPW = (IW > rqdp_pkg::OFFSET_W) ? IW : rqdp_pkg::OFFSET_W;
    localparam int CNTW = (IW > rqdp_pkg::COUNT_W) ? IW : rqdp_pkg::COUNT_W;
    localparam logic [AW-1:0] DEPTH_A = AW'(DEPTH);
    localparam logic [IW-1:0] LAST    = IW'(DEPTH - 1);

    logic [SW-1:0] mem [DEPTH];
    logic [SW-1:0] rd_data_reg;

    logic [IW-1:0] head_reg, head_next;
    logic [IW-1:0] tail_reg, tail_next;

    logic [rqdp_pkg::OP_W-1:0]     op_reg;
    logic [SW-1:0]                 entry_reg;
    logic [rqdp_pkg::OFFSET_W-1:0] offset_reg;

    logic                          rsp_valid_reg;
    logic                          ok_reg;
    logic [rqdp_pkg::ENTRY_W-1:0]  entry_out_reg;
    logic [rqdp_pkg::COUNT_W-1:0]  count_reg;
    logic                          empty_reg;
    logic                          full_reg;

    logic [IW-1:0] head_inc, tail_inc;
    logic [AW-1:0] cnt_wide, cnt_after_wide;
    logic [IW-1:0] cnt, cnt_after;
    logic          is_full;
    logic          peek_hit, peek_hit_reg_item;
    logic [IW-1:0] peek_n;
    logic [AW-1:0] pos_old_wide, pos_new_wide;
    logic [IW-1:0] peek_pos, rd_addr;
    logic          wr_en;
    logic          ok_c;
    logic          give_data;
    logic [CNTW-1:0] cnt_after_ext;

    assign head_inc = (head_reg == LAST) ? '0 : head_reg + 1'b1;
    assign tail_inc = (tail_reg == LAST) ? '0 : tail_reg + 1'b1;
    assign is_full  = (tail_inc == head_reg);

    assign cnt_wide = (tail_reg >= head_reg) ? AW'(tail_reg) - AW'(head_reg)
                                             : AW'(tail_reg) + DEPTH_A - AW'(head_reg);
    assign cnt      = cnt_wide[IW-1:0];

    // Slot address for the read issued at the transfer edge
    assign peek_hit     = (offset != '0) && (CMPW'(offset) <= CMPW'(cnt));
    assign peek_n       = peek_hit ? IW'(offset) : IW'(1);
    assign pos_old_wide = AW'(head_reg) + AW'(peek_n);
    assign pos_new_wide = AW'(tail_reg) + DEPTH_A + AW'(1) - AW'(peek_n);

    always_comb
    begin
        if (from_newest)
        begin
            peek_pos = (pos_new_wide >= DEPTH_A) ? IW'(pos_new_wide - DEPTH_A)
                                                 : IW'(pos_new_wide);
        end
        else
        begin
            peek_pos = (pos_old_wide >= DEPTH_A) ? IW'(pos_old_wide - DEPTH_A)
                                                 : IW'(pos_old_wide);
        end
        rd_addr = (op == rqdp_pkg::OP_POP) ? head_inc : peek_pos;
    end

    assign peek_hit_reg_item = (offset_reg != '0) && (CMPW'(offset_reg) <= CMPW'(cnt));

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        ok_c      = 1'b0;
        give_data = 1'b0;
        wr_en     = 1'b0;
        case (op_reg)
            rqdp_pkg::OP_CLEAR:
            begin
                head_next = '0;
                tail_next = '0;
                ok_c      = 1'b1;
            end
            rqdp_pkg::OP_PUSH:
            begin
                if (!is_full)
                begin
                    tail_next = tail_inc;
                    wr_en     = 1'b1;
                    ok_c      = 1'b1;
                end
            end
            rqdp_pkg::OP_PUSH_DROP:
            begin
                if (is_full)
                begin
                    head_next = head_inc;
                end
                tail_next = tail_inc;
                wr_en     = 1'b1;
                ok_c      = 1'b1;
            end
            rqdp_pkg::OP_POP:
            begin
                if (cnt != '0)
                begin
                    head_next = head_inc;
                    ok_c      = 1'b1;
                    give_data = 1'b1;
                end
            end
            rqdp_pkg::OP_PEEK:
            begin
                if (peek_hit_reg_item)
                begin
                    ok_c      = 1'b1;
                    give_data = 1'b1;
                end
            end
            default:
            begin
                ok_c = 1'b0;
            end
        endcase
    end

    assign cnt_after_wide = (tail_next >= head_next) ? AW'(tail_next) - AW'(head_next)
                                                     : AW'(tail_next) + DEPTH_A - AW'(head_next);
    assign cnt_after      = cnt_after_wide[IW-1:0];
    assign cnt_after_ext  = CNTW'(cnt_after);

    assign status.out_free = !rsp_valid_reg || rsp_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.execute && wr_en)
        begin
            mem[tail_inc] <= entry_reg;
        end
        if (cmd.capture)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg     <= op;
            entry_reg  <= entry_in[SW-1:0];
            offset_reg <= offset;
        end
        if (cmd.execute)
        begin
            ok_reg        <= ok_c;
            entry_out_reg <= give_data ? rqdp_pkg::ENTRY_W'(rd_data_reg) : '0;
            count_reg     <= cnt_after_ext[rqdp_pkg::COUNT_W-1:0];
            empty_reg     <= (cnt_after == '0);
            full_reg      <= (cnt_after == LAST);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.execute)
            begin
                head_reg      <= head_next;
                tail_reg      <= tail_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign ok        = ok_reg;
    assign entry_out = entry_out_reg;
    assign count     = count_reg;
    assign empty_res = empty_reg;
    assign full_res  = full_reg;

endmodule

FILE: design/ring_queue_with_drop_and_peek.sv
// Top level of the ring queue with drop and peek.
// Depends on rqdp_pkg, rqdp_item_if, rqdp_result_if, rqdp_ctrl and rqdp_datapath.
//
//   channel | dir | modport | payload
//   req     | in  | sink    | op, from_newest, entry_in, offset
//   rsp     | out | source  | ok, entry_out, count, empty_res, full_res
//
// Each operation passes through the accept and execute states: the transfer edge issues the slot read,
// and the execute state loads the result register once that register is free.
// A new operation is taken while the previous result waits in the result register;
// execution holds while that register still carries an untaken result.
// Reset zeroes head and tail; slot contents are undefined until written.
module ring_queue_with_drop_and_peek #(
    parameter int DEPTH       = rqdp_pkg::DEPTH_DEFAULT,
    parameter int ENTRY_WIDTH = rqdp_pkg::ENTRY_WIDTH_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    rqdp_item_if.sink     req,
    rqdp_result_if.source rsp
);

    rqdp_pkg::ctrl_cmd_t    cmd;
    rqdp_pkg::ctrl_status_t status;

    rqdp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .status    (status),
        .cmd       (cmd)
    );

    rqdp_datapath #(
        .DEPTH       (DEPTH),
        .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .op          (req.op),
        .from_newest (req.from_newest),
        .entry_in    (req.entry_in),
        .offset      (req.offset),
        .rsp_ready   (rsp.ready),
        .rsp_valid   (rsp.valid),
        .ok          (rsp.ok),
        .entry_out   (rsp.entry_out),
        .count       (rsp.count),
        .empty_res   (rsp.empty_res),
        .full_res    (rsp.full_res)
    );

endmodule

FILE: design/rqdp_checker.sv
// Port-level checker for the ring queue with drop and peek, and its bind.
// Depends on rqdp_pkg and ring_queue_with_drop_and_peek.
module rqdp_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         req_valid,
    input logic                         req_ready,
    input logic                         rsp_valid,
    input logic                         rsp_ready,
    input logic                         rsp_ok,
    input logic [rqdp_pkg::ENTRY_W-1:0] rsp_entry_out,
    input logic                         rsp_empty_res,
    input logic                         rsp_full_res
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_entry_out))
        else $error("result dropped or changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("second transfer taken while an operation executes");

    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ok |-> rsp_entry_out == '0)
        else $error("refused operation returned a word");

    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp_empty_res && rsp_full_res))
        else $error("empty and full reported together");

endmodule

bind ring_queue_with_drop_and_peek rqdp_checker u_rqdp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_ok        (rsp.ok),
    .rsp_entry_out (rsp.entry_out),
    .rsp_empty_res (rsp.empty_res),
    .rsp_full_res  (rsp.full_res)
);

FILE: verif/ring_queue_with_drop_and_peek_test.sv
// Self-checking test of ring_queue_with_drop_and_peek: operation transfers go in on req,
// a local ring mirror predicts every result, and each rsp transfer is checked against it.
// Depends on rqdp_pkg, rqdp_item_if, rqdp_result_if and the design top level.
module ring_queue_with_drop_and_peek_test;

    localparam int DEPTH       = rqdp_pkg::DEPTH_DEFAULT;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic                                ok;
        logic [rqdp_pkg::ENTRY_W-1:0]        entry_out;
        logic [rqdp_pkg::COUNT_W-1:0]        count;
        logic                                empty_res;
        logic                                full_res;
    } queue_result_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    rqdp_item_if   req ();
    rqdp_result_if rsp ();

    ring_queue_with_drop_and_peek #(
        .DEPTH       (DEPTH),
        .ENTRY_WIDTH (rqdp_pkg::ENTRY_WIDTH_DEFAULT)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    logic [rqdp_pkg::ENTRY_W-1:0] ring_slots [DEPTH];
    int                           ring_head = 0;
    int                           ring_tail = 0;

    queue_result_t expected_results [$];
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;
    int            hold_cycles   = 0;
    int            mismatches    = 0;
    int            cycle_count   = 0;

    always #5 clk = ~clk;

    function automatic int ring_fill();
        return (ring_tail + DEPTH - ring_head) % DEPTH;
    endfunction

    function automatic queue_result_t apply_queue_op(rqdp_pkg::op_t op, logic newest,
                                                     logic [rqdp_pkg::ENTRY_W-1:0] word,
                                                     logic [rqdp_pkg::OFFSET_W-1:0] n);
        queue_result_t r;
        int            held;
        int            pos;
        int            nn;
        r    = '0;
        held = ring_fill();
        nn   = int'(n);
        case (op)
            rqdp_pkg::OP_CLEAR:
            begin
                ring_head = 0;
                ring_tail = 0;
                r.ok      = 1'b1;
            end
            rqdp_pkg::OP_PUSH:
            begin
                if (held != DEPTH - 1)
                begin
                    ring_tail             = (ring_tail + 1) % DEPTH;
                    ring_slots[ring_tail] = word;
                    r.ok                  = 1'b1;
                end
            end
            rqdp_pkg::OP_PUSH_DROP:
            begin
                if (held == DEPTH - 1)
                    ring_head = (ring_head + 1) % DEPTH;
                ring_tail             = (ring_tail + 1) % DEPTH;
                ring_slots[ring_tail] = word;
                r.ok                  = 1'b1;
            end
            rqdp_pkg::OP_POP:
            begin
                if (held != 0)
                begin
                    ring_head   = (ring_head + 1) % DEPTH;
                    r.entry_out = ring_slots[ring_head];
                    r.ok        = 1'b1;
                end
            end
            rqdp_pkg::OP_PEEK:
            begin
                if (nn >= 1 && nn <= held)
                begin
                    if (newest)
                        pos = (ring_tail + DEPTH + 1 - nn) % DEPTH;
                    else
                        pos = (ring_head + nn) % DEPTH;
                    r.entry_out = ring_slots[pos];
                    r.ok        = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        held        = ring_fill();
        r.count     = rqdp_pkg::COUNT_W'(held);
        r.empty_res = (held == 0);
        r.full_res  = (held == DEPTH - 1);
        return r;
    endfunction

    task automatic send_op(rqdp_pkg::op_t op, logic newest,
                           logic [rqdp_pkg::ENTRY_W-1:0] word,
                           logic [rqdp_pkg::OFFSET_W-1:0] n);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid       <= 1'b1;
        req.op          <= op;
        req.from_newest <= newest;
        req.entry_in    <= word;
        req.offset      <= n;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        expected_results.push_back(apply_queue_op(op, newest, word, n));
    endtask

    task automatic send_random_op(int push_pct);
        int                            pick;
        int                            held;
        rqdp_pkg::op_t                 op;
        logic [rqdp_pkg::ENTRY_W-1:0]  word;
        logic [rqdp_pkg::OFFSET_W-1:0] n;
        pick = $urandom_range(99);
        held = ring_fill();
        if (pick < 2)
            op = rqdp_pkg::OP_CLEAR;
        else if (pick < 2 + push_pct)
            op = ($urandom_range(3) == 0) ? rqdp_pkg::OP_PUSH_DROP : rqdp_pkg::OP_PUSH;
        else if (pick < 2 + push_pct + (98 - push_pct) / 2)
            op = rqdp_pkg::OP_POP;
        else
            op = rqdp_pkg::OP_PEEK;
        case ($urandom_range(15))
            0:       word = '1;
            1:       word = '0;
            default: word = $urandom;
        endcase
        if (held > 0 && $urandom_range(4) != 0)
            n = rqdp_pkg::OFFSET_W'($urandom_range(held, 1));
        else
            n = rqdp_pkg::OFFSET_W'($urandom_range(15));
        send_op(op, 1'($urandom_range(1)), word, n);
    endtask

    task automatic test_empty_queue();
        send_op(rqdp_pkg::OP_POP,  1'b0, $urandom, 4'd0);
        send_op(rqdp_pkg::OP_PEEK, 1'b0, $urandom, 4'd1);
        send_op(rqdp_pkg::OP_PEEK, 1'b1, $urandom, 4'd0);
    endtask

    task automatic test_fill_and_wrap();
        logic [rqdp_pkg::ENTRY_W-1:0] word;
        for (int i = 0; i < DEPTH - 1; i++)
        begin
            case (i)
                0:       word = '1;
                1:       word = '0;
                2:       word = 32'hAAAA_AAAA;
                3:       word = 32'h5555_5555;
                default: word = $urandom;
            endcase
            send_op(rqdp_pkg::OP_PUSH, 1'b0, word, 4'd0);
        end
        send_op(rqdp_pkg::OP_PUSH,      1'b0, '1,            4'd0);
        send_op(rqdp_pkg::OP_PUSH_DROP, 1'b0, 32'h0123_4567, 4'd0);
        send_op(rqdp_pkg::OP_PEEK,      1'b0, $urandom,      4'd15);
        send_op(rqdp_pkg::OP_PEEK,      1'b1, $urandom,      4'd15);
        send_op(rqdp_pkg::OP_PEEK,      1'b1, $urandom,      4'd1);
        send_op(rqdp_pkg::OP_POP,       1'b0, $urandom,      4'd0);
    endtask

    task automatic test_clear();
        send_op(rqdp_pkg::OP_CLEAR,     1'b0, $urandom,      4'd0);
        send_op(rqdp_pkg::OP_PEEK,      1'b0, $urandom,      4'd1);
        send_op(rqdp_pkg::OP_PUSH_DROP, 1'b1, 32'hFEDC_BA98, 4'd15);
    endtask

    task automatic test_random_traffic(int items, int send_pct, int recv_pct);
        int push_pct;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        push_pct      = 45;
        for (int i = 0; i < items; i++)
        begin
            if (i % 40 == 0)
            begin
                case ($urandom_range(2))
                    0:       push_pct = 20;
                    1:       push_pct = 45;
                    default: push_pct = 70;
                endcase
            end
            send_random_op(push_pct);
        end
    endtask

    task automatic test_output_stall();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles   = 300;
        for (int i = 0; i < 40; i++)
            send_random_op(60);
    endtask

    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            rsp.ready   <= 1'b0;
            hold_cycles = hold_cycles - 1;
        end
        else
        begin
            rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin : check_results
        queue_result_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: ok %0b entry_out %h count %0d", rsp.ok,
                             rsp.entry_out, rsp.count);
            end
            else
            begin
                want = expected_results.pop_front();
                if (rsp.ok !== want.ok || rsp.entry_out !== want.entry_out
                    || rsp.count !== want.count || rsp.empty_res !== want.empty_res
                    || rsp.full_res !== want.full_res)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"result mismatch (expected/actual): ok %0b/%0b ",
                                  "entry_out %h/%h count %0d/%0d empty %0b/%0b full %0b/%0b"},
                                 want.ok, rsp.ok, want.entry_out, rsp.entry_out,
                                 want.count, rsp.count, want.empty_res, rsp.empty_res,
                                 want.full_res, rsp.full_res);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        req.valid       = 1'b0;
        req.op          = rqdp_pkg::OP_CLEAR;
        req.from_newest = 1'b0;
        req.entry_in    = '0;
        req.offset      = '0;
        rsp.ready       = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_idle_pct = 37;
        recv_idle_pct = 48;
        test_empty_queue();
        test_fill_and_wrap();
        test_clear();
        test_random_traffic(500, 37, 48);
        test_random_traffic(500, 48, 37);
        test_random_traffic(500, 0, 0);
        test_output_stall();
        req.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
